@@ rtl/command_keyword_matcher_assert.svh @@
// Assertion helpers included by the matcher scan module.
// Each macro expects clk and rst_n in scope.
`ifndef COMMAND_KEYWORD_MATCHER_ASSERT_SVH
`define COMMAND_KEYWORD_MATCHER_ASSERT_SVH

// Property that must hold at every edge outside reset
`define CKM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition at one edge implies a result at the next edge
`define CKM_ASSERT_NEXT(lbl, cond, res, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
    else $error(msg);

`endif

@@ rtl/ckm_pkg.sv @@
// ----------------------------------------------------------------------------
// ckm_pkg
// Shared constants, types and the command name table of the keyword matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package ckm_pkg;

  localparam int MAX_COMMANDS = 16;
  localparam int NAME_SLOTS   = 16;
  localparam int IDX_W        = $clog2(MAX_COMMANDS);
  localparam int SLOT_W       = $clog2(NAME_SLOTS);
  localparam int CNT_W        = $clog2(MAX_COMMANDS + 1);
  localparam int POS_W        = $clog2(NAME_SLOTS + 1);
  localparam int ROM_AW       = IDX_W + SLOT_W;
  localparam int ROW_W        = 8 * NAME_SLOTS;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  // Register map (word index)
  localparam int CFG_AW          = 3;
  localparam logic REG_NUM_COMMANDS = 1'b0;
  localparam logic [4:0] NUM_COMMANDS_RESET = 5'd9;

  // Names left-aligned in a row, zero padded
  localparam logic [ROW_W-1:0] NAME_ROWS [MAX_COMMANDS] = '{
    {"led1-on",  72'h0},
    {"led2-on",  72'h0},
    {"led3-on",  72'h0},
    {"led1-off", 64'h0},
    {"led2-off", 64'h0},
    {"led3-off", 64'h0},
    {"leds-on",  72'h0},
    {"leds-off", 64'h0},
    {"help",     96'h0},
    '0, '0, '0, '0, '0, '0, '0
  };

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_SCAN,
    SC_DONE
  } scan_state_t;

  typedef struct packed {
    logic [7:0]       echo_char;
    logic             prompt_after;
    logic             matched;
    logic [IDX_W-1:0] match_index;
    logic             all_rejected;
  } result_t;

  // Byte of the name table at {entry, slot}
  function automatic logic [7:0] name_byte(input logic [ROM_AW-1:0] addr);
    logic [ROW_W-1:0] row;
    row = NAME_ROWS[addr[ROM_AW-1:SLOT_W]] << {addr[SLOT_W-1:0], 3'b000};
    return row[ROW_W-1 -: 8];
  endfunction

endpackage

`default_nettype wire

@@ rtl/ckm_name_rom.sv @@
// ----------------------------------------------------------------------------
// ckm_name_rom
// Command name table, one byte per read, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ckm_name_rom import ckm_pkg::*; (
  input  wire logic              clk,
  input  wire logic [ROM_AW-1:0] rd_addr,
  output logic      [7:0]        rd_data
);

  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    rd_data_r <= name_byte(rd_addr);
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/ckm_scan.sv @@
// ----------------------------------------------------------------------------
// ckm_scan
// Per-character scan of the name table: one entry read per cycle, compare on
// the following cycle, round state kept in registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ckm_scan import ckm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [4:0]       num_commands,
  input  wire logic             char_valid,
  output logic                  char_ready,
  input  wire logic [7:0]       char_in,
  output logic                  res_valid,
  input  wire logic             res_take,
  output result_t               res
);

  `include "command_keyword_matcher_assert.svh"

  scan_state_t       state_r, state_nxt;
  logic [7:0]        char_r, char_nxt;
  logic [CNT_W-1:0]  iss_r, iss_nxt;
  logic              ev_vld_r, ev_vld_nxt;
  logic [IDX_W-1:0]  ev_idx_r, ev_idx_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [MAX_COMMANDS-1:0] marks_r, marks_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  result_t           res_r, res_nxt;

  logic [CNT_W-1:0]  n_eff;
  logic [7:0]        rd_data;
  logic              eol;
  logic              ended;
  logic              live;
  logic              hit;
  logic              all_rej;
  logic              finish;

  assign n_eff = (num_commands > CNT_W'(MAX_COMMANDS)) ? CNT_W'(MAX_COMMANDS)
                                                        : CNT_W'(num_commands);

  ckm_name_rom u_rom (
    .clk     (clk),
    .rd_addr ({iss_r[IDX_W-1:0], pos_r[SLOT_W-1:0]}),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= SC_IDLE;
      ev_vld_r <= 1'b0;
      pos_r    <= '0;
      marks_r  <= '0;
      total_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      ev_vld_r <= ev_vld_nxt;
      pos_r    <= pos_nxt;
      marks_r  <= marks_nxt;
      total_r  <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r   <= char_nxt;
    iss_r    <= iss_nxt;
    ev_idx_r <= ev_idx_nxt;
    res_r    <= res_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    char_nxt   = char_r;
    iss_nxt    = iss_r;
    ev_vld_nxt = 1'b0;
    ev_idx_nxt = ev_idx_r;
    pos_nxt    = pos_r;
    marks_nxt  = marks_r;
    total_nxt  = total_r;
    res_nxt    = res_r;
    char_ready = 1'b0;
    res_valid  = 1'b0;

    eol    = (char_r == CHAR_LF) || (char_r == CHAR_CR);
    ended  = pos_r[POS_W-1] || (rd_data == 8'h00);
    live   = ev_vld_r && !marks_r[ev_idx_r];
    hit    = live && ended && eol;
    finish = hit || (iss_r >= n_eff);
    all_rej = 1'b0;

    case (state_r)
      SC_IDLE: begin
        char_ready = 1'b1;
        if (char_valid) begin
          char_nxt  = char_in;
          iss_nxt   = '0;
          state_nxt = SC_SCAN;
        end
      end
      SC_SCAN: begin
        // Reject the entry read last cycle on mismatch or early end
        if (live && !hit && (ended || (char_r != rd_data))) begin
          marks_nxt[ev_idx_r] = 1'b1;
          total_nxt           = total_r + CNT_W'(1);
        end
        if (finish) begin
          all_rej = !hit && (total_nxt >= n_eff);
          res_nxt.echo_char    = char_r;
          res_nxt.prompt_after = (char_r == CHAR_LF);
          res_nxt.matched      = hit;
          res_nxt.match_index  = hit ? ev_idx_r : '0;
          res_nxt.all_rejected = all_rej;
          if (hit || all_rej) begin
            pos_nxt   = '0;
            marks_nxt = '0;
            total_nxt = '0;
          end else if (!pos_r[POS_W-1]) begin
            pos_nxt = pos_r + POS_W'(1);
          end
          state_nxt = SC_DONE;
        end else begin
          // Issue the read of the next entry
          ev_vld_nxt = 1'b1;
          ev_idx_nxt = iss_r[IDX_W-1:0];
          iss_nxt    = iss_r + CNT_W'(1);
        end
      end
      SC_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = SC_IDLE;
        end
      end
      default: begin
        state_nxt = SC_IDLE;
      end
    endcase
  end

  assign res = res_r;

  `CKM_ASSERT(a_eval_in_scan, (ev_vld_r |-> (state_r == SC_SCAN)), "compare outside scan")
  `CKM_ASSERT(a_total_matches_marks,
              (32'(total_r) == $countones(marks_r)),
              "reject count drift")
  `CKM_ASSERT(a_done_exclusive,
              ((state_r == SC_DONE) |-> !(res_r.matched && res_r.all_rejected)),
              "match and reject together")
  `CKM_ASSERT(a_round_cleared,
              (((state_r == SC_DONE) && (res_r.matched || res_r.all_rejected)) |->
               ((pos_r == '0) && (marks_r == '0))),
              "round not restarted")
  `CKM_ASSERT_NEXT(a_scan_follows_accept,
                   ((state_r == SC_IDLE) && char_valid),
                   (state_r == SC_SCAN),
                   "accept did not start scan")

endmodule

`default_nettype wire

@@ rtl/command_keyword_matcher.sv @@
// ----------------------------------------------------------------------------
// command_keyword_matcher
// Matches received characters against a table of command names.
//
// Input channel: in_valid / in_ready with in_rx_char, one character per
//   transfer. Result channel: out_valid / out_ready with one result per
//   character: the echoed byte, a prompt flag for LF, a match flag with the
//   winning table index, and an all-rejected flag that restarts the round.
// Configuration: APB-style port, register 0 (byte address 0) holds
//   num_commands, 5 bits, reset 9; values above 16 act as 16. Write it only
//   while the block is idle. pready is tied high.
// Timing: a character is accepted in the idle state; the scan then issues one
//   name-table read per entry up to num_commands (capped at 16), comparing
//   each entry in the cycle after its read, and a done state holds the
//   result until the output register takes it, which drives out_valid.
//   The scan stops early at the first matching entry.
// Reset: synchronous, active low; clears the round (position, reject marks)
//   and restores num_commands to 9.
// Stall: the result register holds a finished result while out_ready is low;
//   the scanner accepts and works on the next character meanwhile and then
//   holds its own result until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module command_keyword_matcher import ckm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_rx_char,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_echo_char,
  output logic                   out_prompt_after,
  output logic                   out_matched,
  output logic [IDX_W-1:0]       out_match_index,
  output logic                   out_all_rejected,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  logic [4:0] num_cmd_r;
  logic       out_valid_r;
  result_t    out_res_r;
  result_t    scan_res;
  logic       scan_valid;
  logic       res_take;
  logic       cfg_wr;

  // Register write on the access phase; the word index is paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_NUM_COMMANDS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cmd_r <= NUM_COMMANDS_RESET;
    end else if (cfg_wr) begin
      num_cmd_r <= pwdata[4:0];
    end
  end

  // Read back: the only register, zero elsewhere
  assign prdata = (paddr[2] == REG_NUM_COMMANDS) ? {27'b0, num_cmd_r} : 32'b0;

  ckm_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .num_commands (num_cmd_r),
    .char_valid   (in_valid),
    .char_ready   (in_ready),
    .char_in      (in_rx_char),
    .res_valid    (scan_valid),
    .res_take     (res_take),
    .res          (scan_res)
  );

  // Advance a finished result into the output register when it is empty or
  // being drained this cycle
  assign res_take = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= scan_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && scan_valid) begin
      out_res_r <= scan_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_echo_char    = out_res_r.echo_char;
  assign out_prompt_after = out_res_r.prompt_after;
  assign out_matched      = out_res_r.matched;
  assign out_match_index  = out_res_r.match_index;
  assign out_all_rejected = out_res_r.all_rejected;

endmodule

`default_nettype wire
